[rtl/core/hpb_pkg.sv]
// Shared types, widths and constants of the banded heater PID controller.
`timescale 1ns / 1ps

package hpb_pkg;

  localparam int TEMP_W      = 16;
  localparam int ERR_W       = TEMP_W + 1;
  localparam int GAIN_W      = 16;
  localparam int BAND_W      = 15;
  localparam int SUM_W       = 24;
  localparam int FD_W        = 32;
  localparam int DRIVE_W     = 8;
  localparam int REGION_W    = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // Shared multiplier: a small signed operand times a wide signed operand.
  localparam int MUL_A_W = GAIN_W + 1;
  localparam int MUL_B_W = 34;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W;

  // Derivative low-pass filter factors in Q0.16 (0.95 and 0.05).
  localparam logic [GAIN_W-1:0] FILT_A = 16'd62259;
  localparam logic [GAIN_W-1:0] FILT_B = 16'd3277;
  localparam int FILT_SHIFT  = 16;
  localparam int DRIVE_SHIFT = 12;
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(32768);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SETPOINT   = 3'd0,
    CFG_GAIN_P     = 3'd1,
    CFG_GAIN_I     = 3'd2,
    CFG_GAIN_D     = 3'd3,
    CFG_BAND       = 3'd4,
    CFG_INT_FLOOR  = 3'd5,
    CFG_INT_CEIL   = 3'd6,
    CFG_DRIVE_MAX  = 3'd7
  } cfg_index_e;

  typedef enum logic [REGION_W-1:0] {
    REGION_FULL = 2'd0,
    REGION_OFF  = 2'd1,
    REGION_PID  = 2'd2
  } region_e;

  typedef enum logic [2:0] {
    MUL_GD_DM  = 3'd0,
    MUL_FILT_B = 3'd1,
    MUL_FILT_A = 3'd2,
    MUL_GP_ERR = 3'd3,
    MUL_GI_SUM = 3'd4
  } mul_sel_e;

  typedef enum logic [2:0] {
    ACC_HOLD       = 3'd0,
    ACC_LOAD_RND   = 3'd1,
    ACC_ADD        = 3'd2,
    ACC_LOAD       = 3'd3,
    ACC_ADD_SUB_FD = 3'd4
  } acc_op_e;

  typedef struct packed {
    logic     load_in;
    logic     upd_sum;
    logic     band_res;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     upd_fd;
    logic     pid_res;
    logic     load_out;
  } cmd_t;

  typedef struct packed {
    logic in_band;
  } status_t;

endpackage

[rtl/core/hpb_ctrl.sv]
// Sequencer of the banded heater PID controller and the output handshake.
`timescale 1ns / 1ps

module hpb_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  hpb_pkg::status_t status_i,
  output hpb_pkg::cmd_t   cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLASS = 9'b000000010,
    S_BMUL  = 9'b000000100,
    S_AMUL  = 9'b000001000,
    S_PMUL  = 9'b000010000,
    S_FILT  = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_DRV   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    cmd_o         = '0;
    cmd_o.mul_sel = hpb_pkg::MUL_GD_DM;
    cmd_o.acc_op  = hpb_pkg::ACC_HOLD;
    in_ready_o    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: begin
        cmd_o.mul_sel = hpb_pkg::MUL_GD_DM;
        if (status_i.in_band) begin
          cmd_o.upd_sum = 1'b1;
          state_d       = S_BMUL;
        end else begin
          cmd_o.band_res = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_BMUL: begin
        cmd_o.mul_sel = hpb_pkg::MUL_FILT_B;
        state_d       = S_AMUL;
      end
      S_AMUL: begin
        cmd_o.mul_sel = hpb_pkg::MUL_FILT_A;
        cmd_o.acc_op  = hpb_pkg::ACC_LOAD_RND;
        state_d       = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.mul_sel = hpb_pkg::MUL_GP_ERR;
        cmd_o.acc_op  = hpb_pkg::ACC_ADD;
        state_d       = S_FILT;
      end
      S_FILT: begin
        cmd_o.mul_sel = hpb_pkg::MUL_GI_SUM;
        cmd_o.acc_op  = hpb_pkg::ACC_LOAD;
        cmd_o.upd_fd  = 1'b1;
        state_d       = S_SUM;
      end
      S_SUM: begin
        cmd_o.acc_op = hpb_pkg::ACC_ADD_SUB_FD;
        state_d      = S_DRV;
      end
      S_DRV: begin
        cmd_o.pid_res = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // The result moves to the output register once the slot is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/hpb_datapath.sv]
// Datapath of the banded heater PID controller: settings, state, shared multiplier.
`timescale 1ns / 1ps

module hpb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [hpb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic signed [hpb_pkg::TEMP_W-1:0]   measured_temp_i,
  input  hpb_pkg::cmd_t                       cmd_i,
  output hpb_pkg::status_t                    status_o,
  output logic [hpb_pkg::DRIVE_W-1:0]         drive_o,
  output logic [hpb_pkg::REGION_W-1:0]        region_o
);

  localparam int TW = hpb_pkg::TEMP_W;
  localparam int EW = hpb_pkg::ERR_W;
  localparam int GW = hpb_pkg::GAIN_W;
  localparam int SW = hpb_pkg::SUM_W;
  localparam int FW = hpb_pkg::FD_W;
  localparam int AW = hpb_pkg::ACC_W;
  localparam int DW = hpb_pkg::DRIVE_W;

  // Settings
  logic signed [TW-1:0]            setpoint_q;
  logic [GW-1:0]                   gain_p_q, gain_i_q, gain_d_q;
  logic [hpb_pkg::BAND_W-1:0]      band_q;
  logic [SW-1:0]                   floor_q, ceil_q;
  logic [DW-1:0]                   dmax_q;

  // Controller state
  logic [SW-1:0]                   error_sum_q;
  logic signed [TW-1:0]            prev_q;
  logic signed [FW-1:0]            fd_q;
  logic                            pending_q;

  // Working registers
  logic signed [TW-1:0]            meas_q;
  logic signed [EW-1:0]            err_q;
  logic signed [hpb_pkg::PROD_W-1:0] prod_q;
  logic signed [AW-1:0]            acc_q;
  logic [DW-1:0]                   res_drive_q, drive_q;
  logic [hpb_pkg::REGION_W-1:0]    res_region_q, region_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= '0;
      gain_p_q   <= '0;
      gain_i_q   <= '0;
      gain_d_q   <= '0;
      band_q     <= hpb_pkg::BAND_W'(160);
      floor_q    <= '0;
      ceil_q     <= SW'(4096);
      dmax_q     <= DW'(255);
    end else if (cfg_we_i) begin
      case (hpb_pkg::cfg_index_e'(cfg_index_i))
        hpb_pkg::CFG_SETPOINT:  setpoint_q <= cfg_data_i[TW-1:0];
        hpb_pkg::CFG_GAIN_P:    gain_p_q   <= cfg_data_i[GW-1:0];
        hpb_pkg::CFG_GAIN_I:    gain_i_q   <= cfg_data_i[GW-1:0];
        hpb_pkg::CFG_GAIN_D:    gain_d_q   <= cfg_data_i[GW-1:0];
        hpb_pkg::CFG_BAND:      band_q     <= cfg_data_i[hpb_pkg::BAND_W-1:0];
        hpb_pkg::CFG_INT_FLOOR: floor_q    <= cfg_data_i[SW-1:0];
        hpb_pkg::CFG_INT_CEIL:  ceil_q     <= cfg_data_i[SW-1:0];
        hpb_pkg::CFG_DRIVE_MAX: dmax_q     <= cfg_data_i[DW-1:0];
        default: ;
      endcase
    end
  end

  // Error and band test
  logic signed [EW-1:0] err_d;
  logic signed [EW-1:0] band_s;
  logic                 above, below;

  assign err_d  = EW'(setpoint_q) - EW'(measured_temp_i);
  assign band_s = $signed({2'b00, band_q});
  assign above  = err_q > band_s;
  assign below  = err_q < -band_s;
  assign status_o.in_band = !above && !below;

  // Integral update with clamp; the floor test wins when floor exceeds ceiling.
  logic [SW-1:0]          sum_base;
  logic signed [SW+1:0]   sum_raw;
  logic [SW-1:0]          sum_d;

  assign sum_base = pending_q ? '0 : error_sum_q;
  assign sum_raw  = $signed({2'b00, sum_base}) + (SW+2)'(err_q);

  always_comb begin
    if (sum_raw < $signed({2'b00, floor_q})) begin
      sum_d = floor_q;
    end else if (sum_raw > $signed({2'b00, ceil_q})) begin
      sum_d = ceil_q;
    end else begin
      sum_d = sum_raw[SW-1:0];
    end
  end

  // Shared multiplier operands
  logic signed [EW-1:0]                  dm;
  logic signed [hpb_pkg::MUL_A_W-1:0]    mul_a;
  logic signed [hpb_pkg::MUL_B_W-1:0]    mul_b;

  assign dm = EW'(meas_q) - EW'(prev_q);

  always_comb begin
    case (cmd_i.mul_sel)
      hpb_pkg::MUL_GD_DM: begin
        mul_a = $signed({1'b0, gain_d_q});
        mul_b = hpb_pkg::MUL_B_W'(dm);
      end
      hpb_pkg::MUL_FILT_B: begin
        mul_a = $signed({1'b0, hpb_pkg::FILT_B});
        mul_b = prod_q[hpb_pkg::MUL_B_W-1:0];
      end
      hpb_pkg::MUL_FILT_A: begin
        mul_a = $signed({1'b0, hpb_pkg::FILT_A});
        mul_b = hpb_pkg::MUL_B_W'(fd_q);
      end
      hpb_pkg::MUL_GP_ERR: begin
        mul_a = $signed({1'b0, gain_p_q});
        mul_b = hpb_pkg::MUL_B_W'(err_q);
      end
      hpb_pkg::MUL_GI_SUM: begin
        mul_a = $signed({1'b0, gain_i_q});
        mul_b = $signed({(hpb_pkg::MUL_B_W-SW)'(0), error_sum_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Filtered derivative: floor of the rounded sum over 2^16, saturated to 32 bits.
  logic signed [AW-1:0] fd_shift;
  logic                 fd_ovf;
  logic signed [FW-1:0] fd_d;

  assign fd_shift = acc_q >>> hpb_pkg::FILT_SHIFT;
  assign fd_ovf   = fd_shift[AW-1:FW-1] != {(AW-FW+1){fd_shift[AW-1]}};

  always_comb begin
    if (fd_ovf) begin
      fd_d = fd_shift[AW-1] ? {1'b1, {(FW-1){1'b0}}} : {1'b0, {(FW-1){1'b1}}};
    end else begin
      fd_d = fd_shift[FW-1:0];
    end
  end

  // Drive from P + I - D: negative gives zero, otherwise clamp to the maximum.
  localparam int DRV_LO = hpb_pkg::DRIVE_SHIFT;
  localparam int DRV_HI = hpb_pkg::DRIVE_SHIFT + DW;
  logic [DW-1:0] pid_drive;

  always_comb begin
    if (acc_q[AW-1]) begin
      pid_drive = '0;
    end else if ((|acc_q[AW-2:DRV_HI]) || (acc_q[DRV_HI-1:DRV_LO] > dmax_q)) begin
      pid_drive = dmax_q;
    end else begin
      pid_drive = acc_q[DRV_HI-1:DRV_LO];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q <= '0;
      prev_q      <= '0;
      fd_q        <= '0;
      pending_q   <= 1'b0;
    end else begin
      if (cmd_i.upd_sum) begin
        error_sum_q <= sum_d;
        pending_q   <= 1'b0;
      end else if (cmd_i.band_res) begin
        pending_q <= 1'b1;
      end
      if (cmd_i.upd_fd) begin
        fd_q   <= fd_d;
        prev_q <= meas_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      meas_q <= measured_temp_i;
      err_q  <= err_d;
    end
    prod_q <= mul_a * mul_b;
    case (cmd_i.acc_op)
      hpb_pkg::ACC_LOAD_RND:   acc_q <= prod_q + $signed(hpb_pkg::ROUND_HALF);
      hpb_pkg::ACC_ADD:        acc_q <= acc_q + prod_q;
      hpb_pkg::ACC_LOAD:       acc_q <= prod_q;
      hpb_pkg::ACC_ADD_SUB_FD: acc_q <= acc_q + prod_q - AW'(fd_q);
      default:                 acc_q <= acc_q;
    endcase
    if (cmd_i.band_res) begin
      res_drive_q  <= above ? dmax_q : '0;
      res_region_q <= above ? hpb_pkg::REGION_FULL : hpb_pkg::REGION_OFF;
    end else if (cmd_i.pid_res) begin
      res_drive_q  <= pid_drive;
      res_region_q <= hpb_pkg::REGION_PID;
    end
    if (cmd_i.load_out) begin
      drive_q  <= res_drive_q;
      region_q <= res_region_q;
    end
  end

  assign drive_o  = drive_q;
  assign region_o = region_q;

endmodule

[rtl/core/heater_pid_with_band.sv]
// Top level of the banded heater PID controller.
`timescale 1ns / 1ps

// Each transfer on the input channel carries one measured temperature (Q12.4) and
// yields exactly one result: a heater drive value and the region it came from.
// An error beyond the band gives full-on or off: the classify state tests the error,
// then the done state loads the output register once the output slot is free.
// Inside the band the PID path runs through the classify state, which also starts
// the first of five passes through the one shared 17 x 34 bit multiplier, four more
// multiply and accumulate steps, the final sum, the drive clamp and the output load.
// The input is ready again in the cycle after the result is loaded, so a new
// temperature is never taken while the previous one is still being processed. A new
// temperature is taken as soon as the previous result sits in the output register,
// even if that result has not yet been transferred. Settings must be written through
// the plain write port only while the block is idle; the block does not enforce this.
module heater_pid_with_band (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  logic [hpb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [hpb_pkg::TEMP_W-1:0]   measured_temp_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hpb_pkg::DRIVE_W-1:0]         drive_o,
  output logic [hpb_pkg::REGION_W-1:0]        region_o
);

  hpb_pkg::cmd_t    cmd;
  hpb_pkg::status_t status;

  hpb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  hpb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .measured_temp_i (measured_temp_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .drive_o         (drive_o),
    .region_o        (region_o)
  );

endmodule
